@@ rtl/trkc_pkg.sv @@
// Shared types and constants of the touch ring keypad classifier.
package trkc_pkg;

  localparam int NUM_PADS  = 4;
  localparam int PAD_W     = 2;
  localparam int RAW_W     = 16;
  localparam int SUM_W     = 20;
  localparam int PCT_W     = 7;
  localparam int LVL_W     = 17;
  localparam int CODE_W    = 4;
  localparam int CFG_IDX_W = 3;

  // Iterative divider geometry.
  localparam int DIV_W  = 24;
  localparam int QUO_W  = 16;
  localparam int STEP_W = 5;
  localparam int P_STEPS = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAD0_FS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD1_FS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD2_FS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAD3_FS = 3'd3;

  // Full scale percentages after reset.
  localparam logic [PCT_W-1:0] PAD0_FS_RESET = 7'd80;
  localparam logic [PCT_W-1:0] PAD1_FS_RESET = 7'd40;
  localparam logic [PCT_W-1:0] PAD2_FS_RESET = 7'd24;
  localparam logic [PCT_W-1:0] PAD3_FS_RESET = 7'd50;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Levels in Q1.16.
  localparam logic [LVL_W-1:0] LVL_ONE       = 17'd65536;
  localparam logic [LVL_W-1:0] MIDDLE_THRESH = 17'd3277;
  localparam logic [LVL_W-1:0] DIAG_THRESH   = 17'd6554;
  localparam logic [LVL_W-1:0] SINGLE_THRESH = 17'd32768;

  // Key codes.
  localparam logic [CODE_W-1:0] KEY_NONE   = 4'd0;
  localparam logic [CODE_W-1:0] KEY_DIAG0  = 4'd2;
  localparam logic [CODE_W-1:0] KEY_DIAG1  = 4'd4;
  localparam logic [CODE_W-1:0] KEY_DIAG2  = 4'd6;
  localparam logic [CODE_W-1:0] KEY_DIAG3  = 4'd8;
  localparam logic [CODE_W-1:0] KEY_MIDDLE = 4'd9;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  typedef logic [NUM_PADS-1:0][RAW_W-1:0] raw_vec_t;

  typedef struct packed {
    logic [NUM_PADS-1:0][SUM_W-1:0] sum;
    logic [NUM_PADS-1:0][PCT_W-1:0] fp;
  } setup_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [QUO_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/trkc_fifo.sv @@
// Small first-in first-out queue built from registers.
module trkc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/trkc_front.sv @@
// Front end: accepts samples, keeps the configuration and the calibration sums.
module trkc_front #(
  parameter int CAL_SAMPLES = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  trkc_pkg::raw_vec_t                 in_raw,
  input  logic                               cfg_we,
  input  logic [trkc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trkc_pkg::PCT_W-1:0]         cfg_wdata,
  output logic                               mid_push,
  output trkc_pkg::raw_vec_t                 mid_wdata,
  input  logic                               mid_full,
  output trkc_pkg::setup_t                   setup
);

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

  logic [CNT_W-1:0] cal_cnt_r, cal_cnt_nxt;
  logic [trkc_pkg::NUM_PADS-1:0][trkc_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [trkc_pkg::NUM_PADS-1:0][trkc_pkg::PCT_W-1:0] fp_r, fp_nxt;
  logic accept;
  logic cal_done;

  assign in_full   = mid_full;
  assign accept    = in_push && !mid_full;
  assign cal_done  = (cal_cnt_r == CNT_W'(CAL_SAMPLES));
  assign mid_push  = accept && cal_done;
  assign mid_wdata = in_raw;
  assign setup.sum = sum_r;
  assign setup.fp  = fp_r;

  always_comb begin
    cal_cnt_nxt = cal_cnt_r;
    sum_nxt     = sum_r;
    fp_nxt      = fp_r;
    if (accept && !cal_done) begin
      for (int i = 0; i < trkc_pkg::NUM_PADS; i++) begin
        sum_nxt[i] = sum_r[i] + trkc_pkg::SUM_W'(in_raw[i]);
      end
      cal_cnt_nxt = cal_cnt_r + 1'b1;
    end
    if (cfg_we) begin
      case (cfg_index)
        trkc_pkg::REG_PAD0_FS: fp_nxt[0] = cfg_wdata;
        trkc_pkg::REG_PAD1_FS: fp_nxt[1] = cfg_wdata;
        trkc_pkg::REG_PAD2_FS: fp_nxt[2] = cfg_wdata;
        trkc_pkg::REG_PAD3_FS: fp_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_cnt_r <= '0;
      sum_r     <= '0;
      fp_r[0]   <= trkc_pkg::PAD0_FS_RESET;
      fp_r[1]   <= trkc_pkg::PAD1_FS_RESET;
      fp_r[2]   <= trkc_pkg::PAD2_FS_RESET;
      fp_r[3]   <= trkc_pkg::PAD3_FS_RESET;
    end else begin
      cal_cnt_r <= cal_cnt_nxt;
      sum_r     <= sum_nxt;
      fp_r      <= fp_nxt;
    end
  end

  a_cal_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= CNT_W'(CAL_SAMPLES))
    else $error("calibration count ran past its limit");

  a_no_classify_while_calibrating: assert property (@(posedge clk) disable iff (!rst_n)
    !cal_done |=> ($past(accept) ? 1'b1 : $stable(sum_r)))
    else $error("calibration sums changed without an accepted sample");

endmodule

@@ rtl/trkc_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module trkc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  trkc_pkg::div_req_t req,
  output trkc_pkg::div_rsp_t rsp
);

  // The caller guarantees dividend < divisor << steps, so steps quotient bits suffice
  // and the shifted divisor fits the remainder width.
  logic [trkc_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [trkc_pkg::DIV_W-1:0]  dsh_r, dsh_nxt;
  logic [trkc_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [trkc_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic                        bit_set;

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_set  = (rem_r >= dsh_r);
    if (req.start) begin
      rem_nxt  = req.dividend;
      dsh_nxt  = trkc_pkg::DIV_W'(req.divisor) << (req.steps - 1'b1);
      quo_nxt  = '0;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (bit_set) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[trkc_pkg::QUO_W-2:0], bit_set};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == trkc_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

endmodule

@@ rtl/trkc_back.sv @@
// Back end: per-pad level computation through the shared divider, then key classification.
module trkc_back #(
  parameter int CAL_SAMPLES = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  trkc_pkg::setup_t             setup,
  input  logic                         mid_empty,
  input  trkc_pkg::raw_vec_t           mid_rdata,
  output logic                         mid_pop,
  output trkc_pkg::div_req_t           div_req,
  input  trkc_pkg::div_rsp_t           div_rsp,
  input  logic                         out_full,
  output logic                         out_push,
  output logic [trkc_pkg::CODE_W-1:0]  out_code
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BASE   = 3'd1;
  localparam logic [2:0] ST_PAD    = 3'd3;
  localparam logic [2:0] ST_PDIV   = 3'd4;
  localparam logic [2:0] ST_QCHK   = 3'd5;
  localparam logic [2:0] ST_LDIV   = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  // The baseline is the calibration sum times a rounded-up reciprocal of CAL_SAMPLES.
  // The extra fraction bits keep the product exact for every sum that fits SUM_W bits.
  localparam int RECIP_SHIFT = trkc_pkg::SUM_W + $clog2(CAL_SAMPLES);
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = trkc_pkg::SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  logic [2:0]                    state_r, state_nxt;
  logic [trkc_pkg::PAD_W-1:0]    pad_r, pad_nxt;
  logic                          base_ok_r, base_ok_nxt;
  logic [trkc_pkg::NUM_PADS-1:0][trkc_pkg::RAW_W-1:0] base_r, base_nxt;
  trkc_pkg::raw_vec_t            raw_r, raw_nxt;
  logic [trkc_pkg::NUM_PADS-1:0][trkc_pkg::LVL_W-1:0] lvl_r, lvl_nxt;
  logic [trkc_pkg::PCT_W-1:0]    q_r, q_nxt;

  logic [trkc_pkg::RAW_W-1:0]    base_cur;
  logic [trkc_pkg::RAW_W-1:0]    raw_cur;
  logic [trkc_pkg::RAW_W-1:0]    drop_cur;
  logic [trkc_pkg::PCT_W-1:0]    fp_cur;
  logic [PROD_W-1:0]             base_prod;
  logic [trkc_pkg::RAW_W-1:0]    base_div;
  logic                          last_pad;
  logic                          advance;

  logic [trkc_pkg::NUM_PADS-1:0] over_mid;
  logic [trkc_pkg::NUM_PADS-1:0] over_diag;
  logic [trkc_pkg::PAD_W-1:0]    best;
  logic [2:0]                    n_diag;

  assign base_cur  = base_r[pad_r];
  assign raw_cur   = raw_r[pad_r];
  assign drop_cur  = (base_cur > raw_cur) ? (base_cur - raw_cur) : '0;
  assign fp_cur    = setup.fp[pad_r];
  assign last_pad  = (pad_r == trkc_pkg::PAD_W'(trkc_pkg::NUM_PADS - 1));
  assign base_prod = PROD_W'(setup.sum[pad_r]) * PROD_W'(RECIP);
  assign base_div  = base_prod[RECIP_SHIFT +: trkc_pkg::RAW_W];

  // Classification of the four registered levels.
  always_comb begin
    best = '0;
    for (int i = 0; i < trkc_pkg::NUM_PADS; i++) begin
      over_mid[i]  = (lvl_r[i] > trkc_pkg::MIDDLE_THRESH);
      over_diag[i] = (lvl_r[i] > trkc_pkg::DIAG_THRESH);
    end
    n_diag = 3'($countones(over_diag));
    for (int i = 1; i < trkc_pkg::NUM_PADS; i++) begin
      if (lvl_r[i] > lvl_r[best]) begin
        best = trkc_pkg::PAD_W'(i);
      end
    end
    if (&over_mid) begin
      out_code = trkc_pkg::KEY_MIDDLE;
    end else if (n_diag == 3'd2) begin
      // Pad 0 only leads a diagonal when pad 3 is not its partner.
      if (over_diag[0] && !over_diag[3]) begin
        out_code = trkc_pkg::KEY_DIAG0;
      end else if (over_diag[1]) begin
        out_code = trkc_pkg::KEY_DIAG1;
      end else if (over_diag[2]) begin
        out_code = trkc_pkg::KEY_DIAG2;
      end else begin
        out_code = trkc_pkg::KEY_DIAG3;
      end
    end else if (lvl_r[best] < trkc_pkg::SINGLE_THRESH) begin
      out_code = trkc_pkg::KEY_NONE;
    end else begin
      out_code = {1'b0, best, 1'b1};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pad_nxt     = pad_r;
    base_ok_nxt = base_ok_r;
    base_nxt    = base_r;
    raw_nxt     = raw_r;
    lvl_nxt     = lvl_r;
    q_nxt       = q_r;
    mid_pop     = 1'b0;
    out_push    = 1'b0;
    div_req     = '0;
    advance     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!mid_empty) begin
          mid_pop   = 1'b1;
          raw_nxt   = mid_rdata;
          pad_nxt   = '0;
          state_nxt = base_ok_r ? ST_PAD : ST_BASE;
        end
      end
      ST_BASE: begin
        base_nxt[pad_r] = base_div;
        if (last_pad) begin
          base_ok_nxt = 1'b1;
          pad_nxt     = '0;
          state_nxt   = ST_PAD;
        end else begin
          pad_nxt = pad_r + 1'b1;
        end
      end
      ST_PAD: begin
        if (drop_cur == '0) begin
          lvl_nxt[pad_r] = '0;
          advance        = 1'b1;
        end else if ({drop_cur, 1'b0} >= {1'b0, base_cur}) begin
          // A drop of half the baseline or more saturates the percentage.
          q_nxt     = trkc_pkg::PCT_FULL;
          state_nxt = ST_QCHK;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = trkc_pkg::DIV_W'(drop_cur) *
                             trkc_pkg::DIV_W'(trkc_pkg::PCT_FULL);
          div_req.divisor  = base_cur;
          div_req.steps    = trkc_pkg::STEP_W'(trkc_pkg::P_STEPS);
          state_nxt        = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (div_rsp.done) begin
          q_nxt     = {div_rsp.quotient[trkc_pkg::P_STEPS-1:0], 1'b0};
          state_nxt = ST_QCHK;
        end
      end
      ST_QCHK: begin
        if (q_r == '0) begin
          lvl_nxt[pad_r] = '0;
          advance        = 1'b1;
        end else if (q_r >= fp_cur) begin
          lvl_nxt[pad_r] = trkc_pkg::LVL_ONE;
          advance        = 1'b1;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = trkc_pkg::DIV_W'({q_r, 16'b0});
          div_req.divisor  = trkc_pkg::QUO_W'(fp_cur);
          div_req.steps    = trkc_pkg::STEP_W'(trkc_pkg::QUO_W);
          state_nxt        = ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (div_rsp.done) begin
          lvl_nxt[pad_r] = trkc_pkg::LVL_W'(div_rsp.quotient);
          advance        = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (advance) begin
      if (last_pad) begin
        state_nxt = ST_OUT;
      end else begin
        pad_nxt   = pad_r + 1'b1;
        state_nxt = ST_PAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pad_r     <= '0;
      base_ok_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pad_r     <= pad_nxt;
      base_ok_r <= base_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    raw_r  <= raw_nxt;
    lvl_r  <= lvl_nxt;
    q_r    <= q_nxt;
  end

  a_div_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while still busy");

  a_div_done_awaited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_PDIV || state_r == ST_LDIV))
    else $error("divider finished while nobody was waiting for it");

  a_pad_after_baseline: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD || state_r == ST_QCHK) |-> base_ok_r)
    else $error("pad level worked out before the baselines were known");

endmodule

@@ rtl/touch_ring_keypad_classifier.sv @@
// A classified sample reaches the result queue once every pad has been worked out, a touched
// pad needing up to two runs of the single shared iterative divider; the first sample also
// waits while the baselines are derived, one pad at a time.
// Throughput: one calibration sample per cycle, then classified samples one at a time, the
// next taken only when the last is queued; two-entry queues decouple both sides.
// Reset (synchronous, rst_n low) clears sums and count, sets full scales to 80/40/24/50 %.
module touch_ring_keypad_classifier #(
  parameter int CAL_SAMPLES = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [trkc_pkg::RAW_W-1:0]        in_pad0_raw,
  input  logic [trkc_pkg::RAW_W-1:0]        in_pad1_raw,
  input  logic [trkc_pkg::RAW_W-1:0]        in_pad2_raw,
  input  logic [trkc_pkg::RAW_W-1:0]        in_pad3_raw,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [trkc_pkg::CODE_W-1:0]       out_key_code,
  input  logic                              cfg_we,
  input  logic [trkc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trkc_pkg::PCT_W-1:0]        cfg_wdata
);

  // The front end takes every transaction; during calibration it folds the readings
  // into the per-pad sums, afterwards it hands the sample to the level engine queue.
  trkc_pkg::raw_vec_t                in_raw;
  trkc_pkg::raw_vec_t                mid_wdata;
  trkc_pkg::raw_vec_t                mid_rdata;
  trkc_pkg::setup_t                  setup;
  trkc_pkg::div_req_t                div_req;
  trkc_pkg::div_rsp_t                div_rsp;
  logic                              mid_push;
  logic                              mid_full;
  logic                              mid_pop;
  logic                              mid_empty;
  logic                              out_push;
  logic                              out_full;
  logic [trkc_pkg::CODE_W-1:0]       out_code;

  assign in_raw[0] = in_pad0_raw;
  assign in_raw[1] = in_pad1_raw;
  assign in_raw[2] = in_pad2_raw;
  assign in_raw[3] = in_pad3_raw;

  trkc_front #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_raw    (in_raw),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mid_push  (mid_push),
    .mid_wdata (mid_wdata),
    .mid_full  (mid_full),
    .setup     (setup)
  );

  // Queue of samples waiting for the level engine.
  trkc_fifo #(
    .WIDTH (trkc_pkg::NUM_PADS * trkc_pkg::RAW_W),
    .DEPTH (trkc_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  // The level engine derives the baselines once by a reciprocal multiplication, then
  // each pad's drop percentage and Q1.16 level, sharing one divider for the last two.
  trkc_back #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .setup     (setup),
    .mid_empty (mid_empty),
    .mid_rdata (mid_rdata),
    .mid_pop   (mid_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_code  (out_code)
  );

  trkc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Result queue: the oldest key code sits on out_key_code while out_empty is low.
  trkc_fifo #(
    .WIDTH (trkc_pkg::CODE_W),
    .DEPTH (trkc_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_code),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_key_code),
    .empty (out_empty)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the touch ring keypad classifier, with its scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import trkc_pkg::*;

  // Calibration length; the block is built with the same value.
  localparam int CAL_SAMPLES      = 10;
  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 8;
  // One phase per full-scale setting: phase 0 keeps the reset values.
  localparam int PHASES           = 8;
  localparam int PHASE_SAMPLES    = 225;
  localparam int DIRECTED_TOUCHES = 15;
  // These hold-offs cover the longest time a classified sample can take, the first
  // one included while the baselines are derived.
  localparam int SETTLE_CYCLES    = 200;
  localparam int TAIL_CYCLES      = 200;
  // Far above the longest quiet stretch of a correct run.
  localparam int QUIET_LIMIT      = 5000;
  localparam int REPORT_LIMIT     = 10;

  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam logic [PCT_W-1:0] FS_MIN  = 7'd1;
  localparam logic [PCT_W-1:0] FS_TOP  = {PCT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] FS_REG [NUM_PADS] =
    '{REG_PAD0_FS, REG_PAD1_FS, REG_PAD2_FS, REG_PAD3_FS};
  localparam logic [CODE_W-1:0] KEY_SINGLE [NUM_PADS] = '{4'd1, 4'd3, 4'd5, 4'd7};
  localparam logic [CODE_W-1:0] KEY_DIAG [NUM_PADS] =
    '{KEY_DIAG0, KEY_DIAG1, KEY_DIAG2, KEY_DIAG3};

  // The six pad pairs used for the directed diagonal touches.
  localparam int PAIR_A [6] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [6] = '{1, 2, 3, 3, 2, 3};

  // Keeps its own copy of the calibration sums and full-scale registers, works out the
  // key code of every sample accepted after calibration and checks the delivered codes in order.
  class keypad_checker;
    logic [SUM_W-1:0]  base_sum [NUM_PADS];
    int unsigned       cal_taken;
    logic [PCT_W-1:0]  full_pct [NUM_PADS];
    logic [CODE_W-1:0] pending_codes [$];
    int unsigned       samples;
    int unsigned       delivered;
    int unsigned       failures;
    int unsigned       code_hist [16];

    function new();
      foreach (base_sum[i]) base_sum[i] = '0;
      foreach (code_hist[i]) code_hist[i] = 0;
      cal_taken = 0;
      samples   = 0;
      delivered = 0;
      failures  = 0;
      full_pct[0] = PAD0_FS_RESET;
      full_pct[1] = PAD1_FS_RESET;
      full_pct[2] = PAD2_FS_RESET;
      full_pct[3] = PAD3_FS_RESET;
    endfunction

    // Writes to indexes past the last pad are dropped by the block.
    function void set_full_scale(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] val);
      if (idx < NUM_PADS) full_pct[idx] = val;
    endfunction

    // Touch level of one pad in Q1.16.
    function int unsigned touch_level(int unsigned base, int unsigned raw, int unsigned fs);
      int unsigned drop, pct, q, lvl;
      if (base == 0) return 0;
      drop = (base > raw) ? base - raw : 0;
      pct  = drop * PCT_FULL / base;
      if (pct > PCT_FULL) pct = PCT_FULL;
      q = 2 * pct;
      if (q > PCT_FULL) q = PCT_FULL;
      if (q == 0) return 0;
      if (fs == 0) return LVL_ONE;
      lvl = q * LVL_ONE / fs;
      return (lvl > LVL_ONE) ? LVL_ONE : lvl;
    endfunction

    function logic [CODE_W-1:0] classify_touch(raw_vec_t raws);
      int unsigned lvl [NUM_PADS];
      int n_mid, n_diag, best;
      n_mid  = 0;
      n_diag = 0;
      best   = 0;
      for (int i = 0; i < NUM_PADS; i++) begin
        lvl[i] = touch_level(base_sum[i] / CAL_SAMPLES, raws[i], full_pct[i]);
        if (lvl[i] > MIDDLE_THRESH) n_mid++;
        if (lvl[i] > DIAG_THRESH) n_diag++;
      end
      if (n_mid == NUM_PADS) return KEY_MIDDLE;
      // A diagonal names the first of its two pads, except that the pair of
      // pads 3 and 0 wraps round and is named after pad 3.
      if (n_diag == 2) begin
        for (int i = 0; i < NUM_PADS; i++) begin
          if (lvl[i] > DIAG_THRESH && !(i == 0 && lvl[NUM_PADS-1] > DIAG_THRESH))
            return KEY_DIAG[i];
        end
      end
      for (int i = 1; i < NUM_PADS; i++) begin
        if (lvl[i] > lvl[best]) best = i;
      end
      return (lvl[best] < SINGLE_THRESH) ? KEY_NONE : KEY_SINGLE[best];
    endfunction

    function void note_sample(raw_vec_t raws);
      logic [CODE_W-1:0] code;
      samples++;
      if (cal_taken < CAL_SAMPLES) begin
        foreach (base_sum[i]) base_sum[i] = base_sum[i] + SUM_W'(raws[i]);
        cal_taken++;
      end else begin
        code = classify_touch(raws);
        pending_codes.push_back(code);
        code_hist[code]++;
      end
    endfunction

    function void check_code(logic [CODE_W-1:0] got);
      logic [CODE_W-1:0] want;
      delivered++;
      if (pending_codes.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: key code %0d delivered with none outstanding", got);
      end else begin
        want = pending_codes.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("ERROR: key code #%0d is %0d, expected %0d", delivered, got, want);
        end
      end
    endfunction
  endclass

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_push      = 1'b0;
  logic                 in_full;
  logic [RAW_W-1:0]     in_pad0_raw  = '0;
  logic [RAW_W-1:0]     in_pad1_raw  = '0;
  logic [RAW_W-1:0]     in_pad2_raw  = '0;
  logic [RAW_W-1:0]     in_pad3_raw  = '0;
  logic                 out_empty;
  logic                 out_pop      = 1'b0;
  logic [CODE_W-1:0]    out_key_code;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [PCT_W-1:0]     cfg_wdata    = '0;

  keypad_checker keypad = new();

  // Sums of the calibration readings as sent, so that touches can be aimed at a
  // chosen drop below each baseline.
  int unsigned cal_sum [NUM_PADS] = '{0, 0, 0, 0};
  int          burst_left   = 0;
  int unsigned quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  touch_ring_keypad_classifier #(.CAL_SAMPLES(CAL_SAMPLES)) dut (.*);

  // Every transaction on either channel, and every register write, is seen here
  // with the values that stood just before the edge.  The watchdog counts the
  // cycles in which neither channel moves.
  always @(posedge clk) begin : watch_channels
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) keypad.set_full_scale(cfg_index, cfg_wdata);
      if (in_push && !in_full) begin
        keypad.note_sample({in_pad3_raw, in_pad2_raw, in_pad1_raw, in_pad0_raw});
        moved = 1'b1;
      end
      if (out_pop && !out_empty) begin
        keypad.check_code(out_key_code);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // The receiver switches among three habits at random: it either takes every result
  // at once, takes them at random, or sits out long stalls.
  int pop_mode      = 0;
  int pop_mode_left = 0;
  int hold_left     = 0;

  always @(posedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode      = $urandom_range(0, 2);
      pop_mode_left = $urandom_range(100, 600);
    end else begin
      pop_mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        default: begin
          out_pop <= 1'b1;
          if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 60);
        end
      endcase
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
    $display("FAIL touch_ring_keypad_classifier");
    $finish;
  end

  // Reading of a pad pressed the given percentage below its baseline.
  function automatic logic [RAW_W-1:0] pressed(int pad, int unsigned drop_pct);
    int unsigned base;
    base = cal_sum[pad] / CAL_SAMPLES;
    return RAW_W'(base - base * drop_pct / PCT_FULL);
  endfunction

  // Untouched pad: at or a little above its baseline.
  function automatic logic [RAW_W-1:0] resting(int pad);
    int unsigned r;
    r = cal_sum[pad] / CAL_SAMPLES + $urandom_range(0, 400);
    return (r > RAW_MAX) ? RAW_MAX : RAW_W'(r);
  endfunction

  function automatic logic [RAW_W-1:0] brushed(int pad);
    return $urandom_range(0, 1) ? resting(pad) : pressed(pad, $urandom_range(0, 12));
  endfunction

  // Pads 0 and 1 get large baselines, pad 2 a modest one and pad 3 one of a few
  // counts, so that its drop moves in coarse steps.  The raw extremes are part
  // of the calibration too.
  function automatic raw_vec_t calibration_sample(int k);
    raw_vec_t r;
    r[0] = (k == 0) ? '0 : (k == 1) ? RAW_MAX : RAW_W'($urandom_range(30000, 50000));
    r[1] = (k == 1) ? '0 : (k == 2) ? RAW_MAX : RAW_W'($urandom_range(20000, 60000));
    r[2] = (k == 3) ? '0 : RAW_W'($urandom_range(800, 2000));
    r[3] = (k == 4) ? '0 : RAW_W'($urandom_range(1, 60));
    foreach (cal_sum[i]) cal_sum[i] += r[i];
    return r;
  endfunction

  // Directed touches: no touch, readings above the baseline, all pads fully
  // pressed, each pad alone, every pair of pads, a weak press of one pad and
  // three pads at once.
  function automatic raw_vec_t directed_touch(int step);
    raw_vec_t r;
    for (int i = 0; i < NUM_PADS; i++) begin
      r[i] = pressed(i, 0);
      case (step)
        1: r[i] = RAW_MAX;
        2: r[i] = '0;
        3, 4, 5, 6: if (i == step - 3) r[i] = '0;
        7, 8, 9, 10, 11, 12: if (i == PAIR_A[step-7] || i == PAIR_B[step-7]) r[i] = '0;
        13: if (i == 0) r[i] = pressed(0, 10);
        14: if (i != NUM_PADS - 1) r[i] = '0;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Mostly shaped touches with random depth, the rest plain noise.
  function automatic raw_vec_t random_touch();
    raw_vec_t r;
    int kind, a, b;
    kind = $urandom_range(0, 9);
    a    = $urandom_range(0, NUM_PADS - 1);
    b    = (a + $urandom_range(1, NUM_PADS - 1)) % NUM_PADS;
    for (int i = 0; i < NUM_PADS; i++) begin
      case (kind)
        0, 1: begin
          if ($urandom_range(0, 7) == 0) r[i] = $urandom_range(0, 1) ? RAW_MAX : '0;
          else r[i] = RAW_W'($urandom);
        end
        2, 3: r[i] = pressed(i, $urandom_range(3, 100));
        4, 5: r[i] = (i == a || i == b) ? pressed(i, $urandom_range(5, 100)) : brushed(i);
        6, 7: r[i] = (i == a) ? pressed(i, $urandom_range(0, 100)) : brushed(i);
        default: begin
          case ($urandom_range(0, 2))
            0: r[i] = resting(i);
            1: r[i] = brushed(i);
            default: r[i] = pressed(i, $urandom_range(0, 100));
          endcase
        end
      endcase
    end
    return r;
  endfunction

  // Sends one sample.  The sender works in bursts; between bursts it drops
  // push for a random gap, and sometimes for none at all.  Push is left high on
  // return so that back-to-back transactions need no second assignment.
  task automatic push_sample(input raw_vec_t raws);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_push     <= 1'b1;
    in_pad0_raw <= raws[0];
    in_pad1_raw <= raws[1];
    in_pad2_raw <= raws[2];
    in_pad3_raw <= raws[3];
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding key code has been taken.
  // The first edge lets the last accepted sample reach the scoreboard.
  task automatic wait_for_codes();
    in_push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (keypad.pending_codes.size() != 0) @(posedge clk);
  endtask

  // Writes all four full-scale registers once the block has gone quiet; with
  // stray set, the unused indexes above them are written with junk as well.
  task automatic program_scales(input logic [PCT_W-1:0] scales [NUM_PADS], input bit stray);
    wait_for_codes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < NUM_PADS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= FS_REG[i];
      cfg_wdata <= scales[i];
      @(posedge clk);
    end
    if (stray) begin
      for (int k = 0; k < NUM_PADS; k++) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(NUM_PADS + k);
        cfg_wdata <= PCT_W'($urandom);
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [PCT_W-1:0] scales [NUM_PADS];
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Calibration, then the directed touches under the reset full-scale values.
    for (int k = 0; k < CAL_SAMPLES; k++) push_sample(calibration_sample(k));
    for (int s = 0; s < DIRECTED_TOUCHES; s++) push_sample(directed_touch(s));

    // Random phases.  The settings run through the smallest and largest legal
    // full scale, zero (which saturates any drop), values above 100 percent,
    // a mixture of all of these and two random sets.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        for (int i = 0; i < NUM_PADS; i++) begin
          case (ph)
            1: scales[i] = FS_MIN;
            2: scales[i] = PCT_FULL;
            3: scales[i] = '0;
            4: scales[i] = FS_TOP;
            5: scales[i] = (i == 0) ? '0 : (i == 1) ? FS_TOP : (i == 2) ? FS_MIN : PCT_FULL;
            default: scales[i] = PCT_W'($urandom);
          endcase
        end
        program_scales(scales, ph == 4 || ph == PHASES - 1);
      end
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // Let the pipeline empty completely now and then, once per phase at least.
        if (n == PHASE_SAMPLES / 2 || $urandom_range(0, 199) == 0) wait_for_codes();
        push_sample(random_touch());
      end
    end

    wait_for_codes();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d samples (%0d calibration) and %0d key codes over %0d settings.",
             keypad.samples, CAL_SAMPLES, keypad.delivered, PHASES);
    $display("Codes predicted: none %0d, single %0d, diagonal %0d, middle %0d; failures %0d.",
             keypad.code_hist[KEY_NONE],
             keypad.code_hist[KEY_SINGLE[0]] + keypad.code_hist[KEY_SINGLE[1]] +
             keypad.code_hist[KEY_SINGLE[2]] + keypad.code_hist[KEY_SINGLE[3]],
             keypad.code_hist[KEY_DIAG0] + keypad.code_hist[KEY_DIAG1] +
             keypad.code_hist[KEY_DIAG2] + keypad.code_hist[KEY_DIAG3],
             keypad.code_hist[KEY_MIDDLE], keypad.failures);
    if (keypad.failures == 0 && keypad.pending_codes.size() == 0) begin
      $display("PASS touch_ring_keypad_classifier");
    end else begin
      if (keypad.pending_codes.size() != 0)
        $display("ERROR: %0d key codes never delivered", keypad.pending_codes.size());
      $display("FAIL touch_ring_keypad_classifier");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/trkc_pkg.sv
rtl/trkc_fifo.sv
rtl/trkc_front.sv
rtl/trkc_div.sv
rtl/trkc_back.sv
rtl/touch_ring_keypad_classifier.sv
dv/tb_top.sv
